[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/rfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int REG_COUNT      = 8;
  localparam int REG_IDX_W      = 3;
  localparam int OUT_WIDTH      = 32;
  localparam int MUL_SPLIT      = 32;

  typedef enum logic [7:0] {
    OP_ADD_R = 8'h00,
    OP_OR_R  = 8'h08,
    OP_AND_R = 8'h20,
    OP_SUB_R = 8'h28,
    OP_XOR_R = 8'h30,
    OP_CMP_R = 8'h38,
    OP_ADD_I = 8'h80,
    OP_SUB_I = 8'h82,
    OP_MOV_R = 8'h88,
    OP_MOV_I = 8'hC6,
    OP_HALT  = 8'hCD,
    OP_SHL_I = 8'hD0,
    OP_SAR_I = 8'hD2,
    OP_MUL_R = 8'hF6
  } opcode_t;

  typedef struct packed {
    logic wr;
    logic cmp_upd;
    logic cmp_val;
    logic halt_set;
  } alu_ctl_t;

endpackage

`default_nettype wire

[sv/rfa_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfa_alu #(
  parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
  input  logic [7:0]                   opcode,
  input  logic [rfa_pkg::REG_IDX_W-1:0] src_sel,
  input  logic                         halted,
  input  logic [DATA_WIDTH-1:0]        op_a,
  input  logic [DATA_WIDTH-1:0]        op_b,
  output logic [DATA_WIDTH-1:0]        result,
  output rfa_pkg::alu_ctl_t            ctl
);

  logic [DATA_WIDTH-1:0] imm;
  logic [DATA_WIDTH-1:0] mul;

  assign imm = {{(DATA_WIDTH-rfa_pkg::REG_IDX_W){1'b0}}, src_sel};

  generate
    if (DATA_WIDTH <= rfa_pkg::MUL_SPLIT) begin : gen_mul_narrow
      assign mul = op_a * op_b;
    end else begin : gen_mul_split
      localparam int HI_W = DATA_WIDTH - rfa_pkg::MUL_SPLIT;
      logic [2*rfa_pkg::MUL_SPLIT-1:0] p_ll;
      logic [HI_W-1:0]                 p_x;
      // low word only: high-by-high term falls outside the result
      assign p_ll = op_a[rfa_pkg::MUL_SPLIT-1:0] * op_b[rfa_pkg::MUL_SPLIT-1:0];
      assign p_x  = op_a[HI_W-1:0] * op_b[DATA_WIDTH-1:rfa_pkg::MUL_SPLIT]
                  + op_a[DATA_WIDTH-1:rfa_pkg::MUL_SPLIT] * op_b[HI_W-1:0];
      assign mul  = p_ll[DATA_WIDTH-1:0] + {p_x, {rfa_pkg::MUL_SPLIT{1'b0}}};
    end
  endgenerate

  always_comb begin
    result = '0;
    ctl    = '0;
    if (!halted) begin
      case (opcode)
        rfa_pkg::OP_MOV_R: begin result = op_b;        ctl.wr = 1'b1; end
        rfa_pkg::OP_MOV_I: begin result = imm;         ctl.wr = 1'b1; end
        rfa_pkg::OP_ADD_R: begin result = op_a + op_b; ctl.wr = 1'b1; end
        rfa_pkg::OP_ADD_I: begin result = op_a + imm;  ctl.wr = 1'b1; end
        rfa_pkg::OP_SUB_R: begin result = op_a - op_b; ctl.wr = 1'b1; end
        rfa_pkg::OP_SUB_I: begin result = op_a - imm;  ctl.wr = 1'b1; end
        rfa_pkg::OP_MUL_R: begin result = mul;         ctl.wr = 1'b1; end
        rfa_pkg::OP_AND_R: begin result = op_a & op_b; ctl.wr = 1'b1; end
        rfa_pkg::OP_OR_R:  begin result = op_a | op_b; ctl.wr = 1'b1; end
        rfa_pkg::OP_XOR_R: begin result = op_a ^ op_b; ctl.wr = 1'b1; end
        rfa_pkg::OP_SHL_I: begin result = op_a << src_sel; ctl.wr = 1'b1; end
        rfa_pkg::OP_SAR_I: begin
          result = $unsigned($signed(op_a) >>> src_sel);
          ctl.wr = 1'b1;
        end
        rfa_pkg::OP_CMP_R: begin
          ctl.cmp_upd = 1'b1;
          ctl.cmp_val = (op_a == op_b);
        end
        rfa_pkg::OP_HALT: begin
          ctl.halt_set = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/reg_file_alu_executor.sv]
// Register-file ALU executor: runs a small 8086-style instruction subset on eight
// registers held in a synchronous register-file memory.
// Input channel (in_valid / in_stall): one instruction per transfer, an opcode
// byte and an operand byte (bits 5:3 destination, bits 2:0 source or immediate).
// Result channel (out_valid / out_stall): exactly one result per instruction, in
// order: write flag, destination index and value, compare flag and halt mark.
// Pipeline: an accepted instruction reads the register file into the read stage,
// then a single ALU stage writes back and loads the output register.
// Throughput: one instruction per cycle while the receiver does not stall; a result
// written back in the same edge as the next read is forwarded.
// Reset (rst_n low, synchronous) empties the pipeline, clears the compare flag,
// the halt mark and the per-register valid bits; an unwritten register reads 0.
// After a halt instruction every further instruction is reported as no write
// with halted set, until reset.
// While the receiver stalls with a result pending, the ALU stage holds and
// in_stall rises once that stage is occupied; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module reg_file_alu_executor #(
  parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_opcode_byte,
  input  logic [7:0]                          in_operand_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_wrote_register,
  output logic [rfa_pkg::REG_IDX_W-1:0]       out_dest_index,
  output logic signed [rfa_pkg::OUT_WIDTH-1:0] out_dest_value,
  output logic                                out_equal_flag,
  output logic                                out_halted
);

  localparam int IW = rfa_pkg::REG_IDX_W;

  logic [DATA_WIDTH-1:0] mem_r [rfa_pkg::REG_COUNT];
  logic [rfa_pkg::REG_COUNT-1:0] valid_r;

  logic [DATA_WIDTH-1:0] rd_a_r, rd_b_r;
  logic                  s1_valid_r;
  logic [7:0]            s1_op_r;
  logic [IW-1:0]         s1_dst_r, s1_src_r;
  logic                  fwd_en_r;
  logic [IW-1:0]         fwd_idx_r;
  logic [DATA_WIDTH-1:0] fwd_data_r;
  logic                  cmp_r, cmp_nxt;
  logic                  halt_r, halt_nxt;

  logic                     out_valid_r;
  logic                     out_wrote_r;
  logic [IW-1:0]            out_idx_r;
  logic [rfa_pkg::OUT_WIDTH-1:0] out_value_r;
  logic                     out_eq_r;
  logic                     out_halt_r;

  logic adv_out, s1_fire, in_fire, wr_en;
  logic [DATA_WIDTH-1:0] op_a, op_b, result;
  logic [rfa_pkg::OUT_WIDTH-1:0] res_out;
  rfa_pkg::alu_ctl_t ctl;

  assign adv_out  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv_out;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_fire  = in_valid && !in_stall;
  assign wr_en    = s1_fire && ctl.wr;

  // forward the write that landed in the same edge as this read
  always_comb begin
    if (fwd_en_r && fwd_idx_r == s1_dst_r) begin
      op_a = fwd_data_r;
    end else begin
      op_a = valid_r[s1_dst_r] ? rd_a_r : '0;
    end
    if (fwd_en_r && fwd_idx_r == s1_src_r) begin
      op_b = fwd_data_r;
    end else begin
      op_b = valid_r[s1_src_r] ? rd_b_r : '0;
    end
  end

  rfa_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .opcode (s1_op_r),
    .src_sel(s1_src_r),
    .halted (halt_r),
    .op_a   (op_a),
    .op_b   (op_b),
    .result (result),
    .ctl    (ctl)
  );

  generate
    if (DATA_WIDTH >= rfa_pkg::OUT_WIDTH) begin : gen_out_trunc
      assign res_out = result[rfa_pkg::OUT_WIDTH-1:0];
    end else begin : gen_out_ext
      assign res_out = {{(rfa_pkg::OUT_WIDTH-DATA_WIDTH){1'b0}}, result};
    end
  endgenerate

  assign cmp_nxt  = (s1_fire && ctl.cmp_upd) ? ctl.cmp_val : cmp_r;
  assign halt_nxt = (s1_fire && ctl.halt_set) ? 1'b1 : halt_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a_r <= mem_r[in_operand_byte[5:3]];
      rd_b_r <= mem_r[in_operand_byte[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[s1_dst_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
      fwd_en_r   <= 1'b0;
      cmp_r      <= 1'b0;
      halt_r     <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[s1_dst_r] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_en_r   <= wr_en;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      cmp_r  <= cmp_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_opcode_byte;
      s1_dst_r   <= in_operand_byte[5:3];
      s1_src_r   <= in_operand_byte[2:0];
      fwd_idx_r  <= s1_dst_r;
      fwd_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_wrote_r <= ctl.wr;
      out_idx_r   <= ctl.wr ? s1_dst_r : '0;
      out_value_r <= ctl.wr ? res_out : '0;
      out_eq_r    <= cmp_nxt;
      out_halt_r  <= halt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_wrote_register = out_wrote_r;
  assign out_dest_index     = out_idx_r;
  assign out_dest_value     = $signed(out_value_r);
  assign out_equal_flag     = out_eq_r;
  assign out_halted         = out_halt_r;

  `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_r, halt_r)
  `ASSERT_SAME(a_no_write_halted, clk, rst_n, out_valid_r && out_wrote_r, !out_halt_r)
  `ASSERT_SAME(a_idle_fields, clk, rst_n, out_valid_r && !out_wrote_r,
               out_idx_r == '0 && out_value_r == '0)
  `ASSERT_SAME(a_stall_only_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r)

endmodule

`default_nettype wire
